### hdl/bilinear_table_interpolator_macros.svh
// Assertion macros shared by the interpolator RTL.
`ifndef BILINEAR_TABLE_INTERPOLATOR_MACROS_SVH
`define BILINEAR_TABLE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define BTI_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bti assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define BTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bti assertion failed");

`endif

### hdl/bti_pkg.sv
// Shared constants, codes and interface types of the bilinear table interpolator.
package bti_pkg;

  // default axis depths
  localparam int unsigned DEF_TEMP_POINTS   = 8;
  localparam int unsigned DEF_CHARGE_POINTS = 8;

  // field widths
  localparam int unsigned AXIS_W   = 16;
  localparam int unsigned VALUE_W  = 24;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_W    = 4;

  // datapath widths
  localparam int unsigned SPAN_W     = AXIS_W + 1;       // signed axis difference
  localparam int unsigned SPROD_W    = 2 * SPAN_W;       // span times span
  localparam int unsigned ACC_W      = 60;               // weighted sum, |sum| < 2^58
  localparam int unsigned MAG_W      = 58;               // magnitude of the weighted sum
  localparam int unsigned DEN_W      = 2 * AXIS_W;       // |cell area| < 2^32
  localparam int unsigned DIVIDEND_W = MAG_W + 2;        // 2*mag + den

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TEMP   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHARGE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GRID   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HIGH = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd3;

  // configuration register indexes
  localparam logic REG_TEMP_POINTS = 1'b0;
  localparam logic REG_SOC_POINTS  = 1'b1;

  // divider request
  typedef struct packed {
    logic               start;
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic [DEN_W-1:0]   den;
  } div_req_t;

  // divider response
  typedef struct packed {
    logic                done;
    logic                busy;
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
  } div_resp_t;

endpackage

### hdl/bti_div.sv
// Rounding restoring divider with saturation for the interpolator result.
`include "bilinear_table_interpolator_macros.svh"

module bti_div (
  input  logic                clk,
  input  logic                rst,
  input  bti_pkg::div_req_t   req,
  output bti_pkg::div_resp_t  resp
);

  localparam int unsigned NW    = bti_pkg::DIVIDEND_W;
  localparam int unsigned DW    = bti_pkg::DEN_W + 1;
  localparam int unsigned QW    = bti_pkg::VALUE_W;
  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic                          busy;
  logic                          check;
  logic                          done;
  logic                          neg;
  logic [NW-1:0]                 dividend;
  logic [DW-1:0]                 divisor;
  logic [DW-1:0]                 rem;
  logic [QW-1:0]                 quo;
  logic [CNT_W-1:0]              cnt;
  logic [QW-1:0]                 value;
  logic [bti_pkg::STATUS_W-1:0]  status;
  logic [DW:0]                   trial;
  logic [DW:0]                   diff;
  logic                          fits;
  logic                          overflow;

  // one quotient bit per step
  assign trial    = {rem, quo[QW-1]};
  assign diff     = trial - {1'b0, divisor};
  assign fits     = trial >= {1'b0, divisor};
  assign overflow = dividend >= NW'({divisor, {QW{1'b0}}});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      check <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        check <= 1'b1;
      end else if (busy && check) begin
        check <= 1'b0;
        if (neg || overflow) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (busy) begin
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: N = 2*mag + den, D = 2*den, q = floor(N / D)
  always_ff @(posedge clk) begin
    if (req.start) begin
      dividend <= NW'({req.mag, 1'b0}) + NW'(req.den);
      divisor  <= {req.den, 1'b0};
      neg      <= req.neg;
    end else if (busy && check) begin
      rem <= DW'(dividend[NW-1:QW]);
      quo <= dividend[QW-1:0];
      cnt <= CNT_W'(QW);
      if (neg) begin
        // any nonzero negative quotient clamps to zero
        value  <= '0;
        status <= (dividend >= NW'(divisor)) ? bti_pkg::ST_LOW : bti_pkg::ST_OK;
      end else if (overflow) begin
        value  <= bti_pkg::VALUE_MAX;
        status <= bti_pkg::ST_HIGH;
      end
    end else if (busy) begin
      rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[QW-2:0], fits};
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        value  <= {quo[QW-2:0], fits};
        status <= bti_pkg::ST_OK;
      end
    end
  end

  assign resp.done   = done;
  assign resp.busy   = busy;
  assign resp.value  = value;
  assign resp.status = status;

  `BTI_ASSERT_IMPLIES(a_start_when_idle, req.start, !busy)
  `BTI_ASSERT_IMPLIES(a_rem_below_divisor, busy && !check, rem < divisor)
  `BTI_ASSERT_NEXT(a_done_single, done, !done)

endmodule

### hdl/bilinear_table_interpolator.sv
// Bilinear interpolation over a 2-D lookup table: top level.
//
// Input channel s_*: one word per item. tuser carries the kind (load
// temperature breakpoint, load charge breakpoint, load grid value, query).
// Loads write one entry of the axis or grid memories and give no result.
// A query gives one result word on m_*: the interpolated value and a status
// (ok, clamped low, clamped high, zero cell span).
// Configuration: cfg_we/cfg_index/cfg_data set the breakpoint counts in use;
// write them only while the block is idle.
// A query searches both axes in parallel, each step an axis read and then
// a compare; then come the breakpoint reads, the multiply steps with the
// four grid reads, sign handling and the divider (range check, 24 quotient
// bits, hand-off); a negative or saturating quotient leaves after the check.
// The block takes one item at a time; a zero cell span returns after the
// breakpoint reads.
// Reset clears the control state and sets both counts to 8 (or the depth);
// the memories hold nothing valid until loaded.
// A stalled receiver holds the result in the output register; the block
// still takes the next item and waits only to deliver the following result.
`include "bilinear_table_interpolator_macros.svh"

module bilinear_table_interpolator #(
  parameter int unsigned MAX_TEMP_POINTS   = bti_pkg::DEF_TEMP_POINTS,
  parameter int unsigned MAX_CHARGE_POINTS = bti_pkg::DEF_CHARGE_POINTS
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // row_index[2:0], col_index[5:3], load_value[29:6],
                                // temperature[45:30], charge[61:46], zero[63:62]
  input  logic [1:0]  s_tuser,  // kind[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // resistance[23:0], status[25:24], zero[31:26]
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int unsigned AW    = bti_pkg::AXIS_W;
  localparam int unsigned VW    = bti_pkg::VALUE_W;
  localparam int unsigned SW    = bti_pkg::STATUS_W;
  localparam int unsigned SPW   = bti_pkg::SPAN_W;
  localparam int unsigned SPPW  = bti_pkg::SPROD_W;
  localparam int unsigned ACCW  = bti_pkg::ACC_W;
  localparam int unsigned TI_W  = $clog2(MAX_TEMP_POINTS);
  localparam int unsigned CI_W  = $clog2(MAX_CHARGE_POINTS);
  localparam int unsigned TU_W  = $clog2(MAX_TEMP_POINTS + 1);
  localparam int unsigned CU_W  = $clog2(MAX_CHARGE_POINTS + 1);
  localparam int unsigned GRID_DEPTH = MAX_TEMP_POINTS * MAX_CHARGE_POINTS;
  localparam int unsigned GA_W  = $clog2(GRID_DEPTH);
  localparam int unsigned T_RESET_USED = (MAX_TEMP_POINTS < 8) ? MAX_TEMP_POINTS : 8;
  localparam int unsigned C_RESET_USED = (MAX_CHARGE_POINTS < 8) ? MAX_CHARGE_POINTS : 8;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_BP0  = 4'd2;
  localparam logic [3:0] S_BP1  = 4'd3;
  localparam logic [3:0] S_BP2  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_NORM = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_PUT  = 4'd8;

  localparam logic [2:0] MUL_LAST = 3'd5;
  localparam logic [2:0] MUL_DEN  = 3'd4;

  // input word fields
  logic [bti_pkg::KIND_W-1:0] kind;
  logic [2:0]                 row_index;
  logic [2:0]                 col_index;
  logic [VW-1:0]              load_value;
  logic [AW-1:0]              temperature;
  logic [AW-1:0]              charge;

  assign kind        = s_tuser;
  assign row_index   = s_tdata[2:0];
  assign col_index   = s_tdata[5:3];
  assign load_value  = s_tdata[29:6];
  assign temperature = s_tdata[45:30];
  assign charge      = s_tdata[61:46];

  // state
  logic [3:0]             state;
  logic [TU_W-1:0]        t_used;
  logic [CU_W-1:0]        c_used;
  logic [AW-1:0]          qx;
  logic [AW-1:0]          qy;
  logic [TI_W-1:0]        ti;
  logic [CI_W-1:0]        ci;
  logic                   tdone;
  logic                   cdone;
  logic                   phase;
  logic [AW-1:0]          x1;
  logic [AW-1:0]          y1;
  logic signed [SPW-1:0]  span_a;
  logic signed [SPW-1:0]  span_b;
  logic signed [SPW-1:0]  span_c;
  logic signed [SPW-1:0]  span_d;
  logic signed [SPW-1:0]  span_dx;
  logic signed [SPW-1:0]  span_dy;
  logic [2:0]             step;
  logic signed [SPPW-1:0] sp;
  logic signed [ACCW-1:0] prod;
  logic signed [ACCW-1:0] acc;
  logic [VW-1:0]          res_value;
  logic [SW-1:0]          res_status;
  logic [VW-1:0]          out_value;
  logic [SW-1:0]          out_status;

  // memories
  logic [AW-1:0] tmem [MAX_TEMP_POINTS];
  logic [AW-1:0] cmem [MAX_CHARGE_POINTS];
  logic [VW-1:0] gmem [GRID_DEPTH];
  logic [AW-1:0] t_rdata;
  logic [AW-1:0] c_rdata;
  logic [VW-1:0] g_rdata;

  logic            accept;
  logic            t_we;
  logic            c_we;
  logic            g_we;
  logic [GA_W-1:0] g_waddr;
  logic [TI_W-1:0] t_raddr;
  logic [CI_W-1:0] c_raddr;
  logic [GA_W-1:0] g_raddr;
  logic            t_adv;
  logic            c_adv;
  logic            put_fire;
  logic signed [SPW-1:0]  mul_l;
  logic signed [SPW-1:0]  mul_r;
  logic [ACCW-1:0]        acc_abs;
  logic [SPPW-1:0]        sp_abs;

  bti_pkg::div_req_t  div_req;
  bti_pkg::div_resp_t div_resp;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign put_fire = (state == S_PUT) && (!m_tvalid || m_tready);

  // load decode, out-of-range loads are dropped
  assign t_we = accept && (kind == bti_pkg::KIND_TEMP)
                && (32'(row_index) < MAX_TEMP_POINTS);
  assign c_we = accept && (kind == bti_pkg::KIND_CHARGE)
                && (32'(col_index) < MAX_CHARGE_POINTS);
  assign g_we = accept && (kind == bti_pkg::KIND_GRID)
                && (32'(row_index) < MAX_TEMP_POINTS)
                && (32'(col_index) < MAX_CHARGE_POINTS);
  assign g_waddr = GA_W'(32'(row_index) * MAX_CHARGE_POINTS + 32'(col_index));

  // read addresses: lower breakpoint in S_BP0, upper one otherwise
  assign t_raddr = (state == S_BP0) ? ti : ti + TI_W'(1);
  assign c_raddr = (state == S_BP0) ? ci : ci + CI_W'(1);
  // grid corner per multiply step: row offset in bit 0, column offset in bit 1
  assign g_raddr = GA_W'((32'(ti) + 32'(step[0])) * MAX_CHARGE_POINTS
                         + 32'(ci) + 32'(step[1]));

  // axis and grid memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[TI_W'(row_index)] <= load_value[AW-1:0];
    end
    t_rdata <= tmem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[CI_W'(col_index)] <= load_value[AW-1:0];
    end
    c_rdata <= cmem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      gmem[g_waddr] <= load_value;
    end
    g_rdata <= gmem[g_raddr];
  end

  // configuration registers, counts clamped to [2, depth]
  always_ff @(posedge clk) begin
    if (rst) begin
      t_used <= TU_W'(T_RESET_USED);
      c_used <= CU_W'(C_RESET_USED);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bti_pkg::REG_TEMP_POINTS: begin
          if (cfg_data < 4'd2) t_used <= TU_W'(2);
          else if (32'(cfg_data) > MAX_TEMP_POINTS) t_used <= TU_W'(MAX_TEMP_POINTS);
          else t_used <= TU_W'(cfg_data);
        end
        bti_pkg::REG_SOC_POINTS: begin
          if (cfg_data < 4'd2) c_used <= CU_W'(2);
          else if (32'(cfg_data) > MAX_CHARGE_POINTS) c_used <= CU_W'(MAX_CHARGE_POINTS);
          else c_used <= CU_W'(cfg_data);
        end
        default: ;
      endcase
    end
  end

  // search step: advance while below the second-to-last point and past the next one
  assign t_adv = !tdone && (TU_W'(ti) + TU_W'(2) < t_used) && (qx > t_rdata);
  assign c_adv = !cdone && (CU_W'(ci) + CU_W'(2) < c_used) && (qy > c_rdata);

  // span pair per multiply step
  always_comb begin
    case (step)
      3'd0:    begin mul_l = span_a;  mul_r = span_c;  end
      3'd1:    begin mul_l = span_b;  mul_r = span_c;  end
      3'd2:    begin mul_l = span_a;  mul_r = span_d;  end
      3'd3:    begin mul_l = span_b;  mul_r = span_d;  end
      default: begin mul_l = span_dx; mul_r = span_dy; end
    endcase
  end

  // sign handling ahead of the divider
  assign acc_abs = acc[ACCW-1] ? ACCW'(-acc) : ACCW'(acc);
  assign sp_abs  = sp[SPPW-1] ? SPPW'(-sp) : SPPW'(sp);

  assign div_req.start = (state == S_NORM);
  assign div_req.neg   = acc[ACCW-1] ^ sp[SPPW-1];
  assign div_req.mag   = acc_abs[bti_pkg::MAG_W-1:0];
  assign div_req.den   = sp_abs[bti_pkg::DEN_W-1:0];

  bti_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
      tdone <= 1'b0;
      cdone <= 1'b0;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (kind == bti_pkg::KIND_QUERY)) begin
            state <= S_SRCH;
            phase <= 1'b0;
            tdone <= 1'b0;
            cdone <= 1'b0;
          end
        end
        S_SRCH: begin
          // phase 0 reads the next breakpoint, phase 1 compares it
          phase <= !phase;
          if (phase) begin
            if (!t_adv) tdone <= 1'b1;
            if (!c_adv) cdone <= 1'b1;
            if (!t_adv && !c_adv) state <= S_BP0;
          end
        end
        S_BP0: state <= S_BP1;
        S_BP1: state <= S_BP2;
        S_BP2: begin
          step <= '0;
          if ((t_rdata == x1) || (c_rdata == y1)) state <= S_PUT;
          else state <= S_MUL;
        end
        S_MUL: begin
          step <= step + 3'd1;
          if (step == MUL_LAST) state <= S_NORM;
        end
        S_NORM: state <= S_DIV;
        S_DIV: begin
          if (div_resp.done) state <= S_PUT;
        end
        S_PUT: begin
          if (put_fire) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    // latch query and clear cell indexes
    if (accept && (kind == bti_pkg::KIND_QUERY)) begin
      qx <= temperature;
      qy <= charge;
      ti <= '0;
      ci <= '0;
    end
    if ((state == S_SRCH) && phase) begin
      if (t_adv) ti <= ti + TI_W'(1);
      if (c_adv) ci <= ci + CI_W'(1);
    end
    // lower breakpoints
    if (state == S_BP1) begin
      x1 <= t_rdata;
      y1 <= c_rdata;
    end
    // spans from the upper breakpoints
    if (state == S_BP2) begin
      span_a  <= $signed({1'b0, t_rdata}) - $signed({1'b0, qx});
      span_b  <= $signed({1'b0, qx}) - $signed({1'b0, x1});
      span_c  <= $signed({1'b0, c_rdata}) - $signed({1'b0, qy});
      span_d  <= $signed({1'b0, qy}) - $signed({1'b0, y1});
      span_dx <= $signed({1'b0, t_rdata}) - $signed({1'b0, x1});
      span_dy <= $signed({1'b0, c_rdata}) - $signed({1'b0, y1});
      res_value  <= '0;
      res_status <= bti_pkg::ST_ZERO;
    end
    // span product, corner-weighted product, accumulate; sp ends as the cell area
    if (state == S_MUL) begin
      if (step <= MUL_DEN) sp <= mul_l * mul_r;
      prod <= $signed({1'b0, g_rdata}) * sp;
      if (step < 3'd2) acc <= '0;
      else acc <= acc + prod;
    end
    if ((state == S_DIV) && div_resp.done) begin
      res_value  <= div_resp.value;
      res_status <= div_resp.status;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (put_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_fire) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

  assign m_tdata = {6'd0, out_status, out_value};

  `BTI_ASSERT_NEXT(a_query_starts_search, accept && (kind == bti_pkg::KIND_QUERY), state == S_SRCH)
  `BTI_ASSERT_IMPLIES(a_div_busy_in_div, div_resp.busy || div_resp.done, state == S_DIV)
  `BTI_ASSERT_IMPLIES(a_zero_span_value, m_tvalid && (out_status == bti_pkg::ST_ZERO), out_value == '0)
  `BTI_ASSERT_IMPLIES(a_put_only_when_free, put_fire, !m_tvalid || m_tready)

endmodule

### verif/bilinear_table_interpolator_tb.sv
// Self-checking testbench for the bilinear table interpolator: loads, queries, count settings.
`timescale 1ns / 1ps

module bilinear_table_interpolator_tb;

  localparam int unsigned GRID_COLS    = bti_pkg::DEF_CHARGE_POINTS;
  localparam int unsigned QUERY_CYCLES = 80;       // worst query latency plus margin
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  // one input word as queued for the driver
  typedef struct packed {
    logic        drain_first;  // hold until every reading is back
    logic [1:0]  kind;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [23:0] load_value;
    logic [15:0] temperature;
    logic [15:0] charge;
  } word_t;

  typedef struct packed {
    logic [bti_pkg::VALUE_W-1:0]  resistance;
    logic [bti_pkg::STATUS_W-1:0] status;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // row[2:0], col[5:3], load_value[29:6],
                               // temperature[45:30], charge[61:46], zero[63:62]
  logic [1:0]  s_tuser = '0;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // resistance[23:0], status[25:24], zero[31:26]
  logic        cfg_we = 1'b0;
  logic        cfg_index = bti_pkg::REG_TEMP_POINTS;
  logic [3:0]  cfg_data = '0;

  bilinear_table_interpolator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state: axes, grid and counts in use
  logic [15:0]                 temp_axis   [0:bti_pkg::DEF_TEMP_POINTS-1];
  logic [15:0]                 charge_axis [0:bti_pkg::DEF_CHARGE_POINTS-1];
  logic [bti_pkg::VALUE_W-1:0] grid_store
                                 [0:bti_pkg::DEF_TEMP_POINTS*bti_pkg::DEF_CHARGE_POINTS-1];
  int unsigned                 temp_in_use = bti_pkg::DEF_TEMP_POINTS;
  int unsigned                 soc_in_use  = bti_pkg::DEF_CHARGE_POINTS;

  // generator-side copy of the axes as queued
  logic [15:0] shadow_temp   [0:bti_pkg::DEF_TEMP_POINTS-1];
  logic [15:0] shadow_charge [0:bti_pkg::DEF_CHARGE_POINTS-1];

  word_t       pending_words[$];
  reading_t    pending_readings[$];
  word_t       in_flight;
  reading_t    want;
  int unsigned words_queued   = 0;
  int unsigned words_accepted = 0;
  int unsigned mismatches     = 0;
  int unsigned idle_left      = 0;
  int unsigned stall_left     = 0;
  int unsigned cycle_count    = 0;
  bit          steady         = 1'b0;
  bit          drain_mark     = 1'b0;
  int unsigned t_base, t_step, c_base, c_step;

  function automatic int unsigned points_in_use(input logic [3:0] v);
    if (v < 2) return 2;
    if (v > bti_pkg::DEF_TEMP_POINTS) return bti_pkg::DEF_TEMP_POINTS;
    return {28'd0, v};
  endfunction

  // bilinear value of the cell holding (t, c), rounded half away from zero
  function automatic reading_t interpolate(input logic [15:0] t, input logic [15:0] c);
    int unsigned xi, yi;
    longint      x, y, x1, x2, y1, y2, dx, dy, num, den, mag, q;
    longint      f11, f12, f21, f22;
    reading_t    r;
    xi = 0;
    while (xi + 2 < temp_in_use && t > temp_axis[xi + 1]) xi++;
    yi = 0;
    while (yi + 2 < soc_in_use && c > charge_axis[yi + 1]) yi++;
    x  = t;
    y  = c;
    x1 = temp_axis[xi];
    x2 = temp_axis[xi + 1];
    y1 = charge_axis[yi];
    y2 = charge_axis[yi + 1];
    dx = x2 - x1;
    dy = y2 - y1;
    if (dx == 0 || dy == 0) begin
      r.resistance = '0;
      r.status     = bti_pkg::ST_ZERO;
      return r;
    end
    f11 = grid_store[xi * GRID_COLS + yi];
    f12 = grid_store[xi * GRID_COLS + yi + 1];
    f21 = grid_store[(xi + 1) * GRID_COLS + yi];
    f22 = grid_store[(xi + 1) * GRID_COLS + yi + 1];
    num = f11 * ((x2 - x) * (y2 - y)) + f21 * ((x - x1) * (y2 - y))
        + f12 * ((x2 - x) * (y - y1)) + f22 * ((x - x1) * (y - y1));
    den = dx * dy;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    mag = (num < 0) ? -num : num;
    q   = (2 * mag + den) / (2 * den);
    if (num < 0) q = -q;
    if (q < 0) begin
      r.resistance = '0;
      r.status     = bti_pkg::ST_LOW;
    end else if (q > longint'(bti_pkg::VALUE_MAX)) begin
      r.resistance = bti_pkg::VALUE_MAX;
      r.status     = bti_pkg::ST_HIGH;
    end else begin
      r.resistance = q[bti_pkg::VALUE_W-1:0];
      r.status     = bti_pkg::ST_OK;
    end
    return r;
  endfunction

  // apply an accepted word to the predictor state
  function automatic void absorb_word(input word_t w);
    case (w.kind)
      bti_pkg::KIND_TEMP:   temp_axis[w.row] = w.load_value[15:0];
      bti_pkg::KIND_CHARGE: charge_axis[w.col] = w.load_value[15:0];
      bti_pkg::KIND_GRID:   grid_store[w.row * GRID_COLS + w.col] = w.load_value;
      default:              pending_readings.push_back(interpolate(w.temperature, w.charge));
    endcase
  endfunction

  function automatic int unsigned pause_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned sender_gap();
    if (steady || $urandom_range(0, 1) == 0) return 0;
    return pause_len();
  endfunction

  task automatic flag(input string what);
    $display("%0t ERROR: %s", $time, what);
    mismatches++;
  endtask

  // fields unused by the kind get random content
  task automatic push_word(input logic [1:0] kind, input logic [2:0] row, input logic [2:0] col,
                           input logic [23:0] value, input logic [15:0] t,
                           input logic [15:0] c);
    word_t w;
    w.kind        = kind;
    w.row         = row;
    w.col         = col;
    w.load_value  = value;
    w.temperature = t;
    w.charge      = c;
    if (kind == bti_pkg::KIND_QUERY) begin
      w.row        = 3'($urandom);
      w.col        = 3'($urandom);
      w.load_value = 24'($urandom);
    end else begin
      w.temperature = 16'($urandom);
      w.charge      = 16'($urandom);
    end
    if (kind == bti_pkg::KIND_TEMP) begin
      w.col                = 3'($urandom);
      w.load_value[23:16]  = 8'($urandom);
      shadow_temp[row]     = value[15:0];
    end
    if (kind == bti_pkg::KIND_CHARGE) begin
      w.row                = 3'($urandom);
      w.load_value[23:16]  = 8'($urandom);
      shadow_charge[col]   = value[15:0];
    end
    w.drain_first = drain_mark;
    drain_mark    = 1'b0;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic load_temp(input int unsigned idx, input logic [15:0] v);
    push_word(bti_pkg::KIND_TEMP, idx[2:0], 3'd0, {8'd0, v}, 16'd0, 16'd0);
  endtask

  task automatic load_charge(input int unsigned idx, input logic [15:0] v);
    push_word(bti_pkg::KIND_CHARGE, 3'd0, idx[2:0], {8'd0, v}, 16'd0, 16'd0);
  endtask

  task automatic load_grid(input int unsigned r, input int unsigned c, input logic [23:0] v);
    push_word(bti_pkg::KIND_GRID, r[2:0], c[2:0], v, 16'd0, 16'd0);
  endtask

  task automatic query(input logic [15:0] t, input logic [15:0] c);
    push_word(bti_pkg::KIND_QUERY, 3'd0, 3'd0, 24'd0, t, c);
  endtask

  // wait for all words taken and readings back, then for a load still in the pipe
  task automatic settle();
    while (words_accepted != words_queued || pending_readings.size() != 0) @(posedge clk);
    repeat (QUERY_CYCLES) @(posedge clk);
  endtask

  task automatic set_counts(input logic [3:0] t, input logic [3:0] c);
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_index   <= bti_pkg::REG_TEMP_POINTS;
    cfg_data    <= t;
    temp_in_use = points_in_use(t);
    @(posedge clk);
    cfg_index   <= bti_pkg::REG_SOC_POINTS;
    cfg_data    <= c;
    soc_in_use  = points_in_use(c);
    @(posedge clk);
    cfg_we      <= 1'b0;
  endtask

  function automatic logic [23:0] grid_pick();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'd0;
    if (r == 1) return bti_pkg::VALUE_MAX;
    if (r < 5) return 24'($urandom_range(0, 255));
    return 24'($urandom);
  endfunction

  // one phase: fresh ascending axes, then a random mix of queries and loads
  task automatic run_phase(input int unsigned n);
    int unsigned i, r, idx;
    t_step = $urandom_range(1, 8000);
    t_base = $urandom_range(0, 65535 - 8 * t_step);
    c_step = $urandom_range(1, 8000);
    c_base = $urandom_range(0, 65535 - 8 * c_step);
    for (i = 0; i < bti_pkg::DEF_TEMP_POINTS; i++)
      load_temp(i, 16'(t_base + i * t_step + $urandom_range(0, t_step / 2)));
    for (i = 0; i < bti_pkg::DEF_CHARGE_POINTS; i++)
      load_charge(i, 16'(c_base + i * c_step + $urandom_range(0, c_step / 2)));
    repeat (n) begin
      if ($urandom_range(0, 49) == 0) drain_mark = 1'b1;
      r   = $urandom_range(0, 99);
      idx = $urandom_range(0, 7);
      if (r < 55) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4:
            query(16'($urandom_range(shadow_temp[0], shadow_temp[temp_in_use - 1])),
                  16'($urandom_range(shadow_charge[0], shadow_charge[soc_in_use - 1])));
          5, 6:
            query(shadow_temp[$urandom_range(0, 7)], shadow_charge[$urandom_range(0, 7)]);
          default:
            query(16'($urandom), 16'($urandom));
        endcase
      end else if (r < 75) begin
        load_grid(idx, $urandom_range(0, 7), grid_pick());
      end else if (r < 90) begin
        if ($urandom_range(0, 1) == 0)
          load_temp(idx, 16'(t_base + idx * t_step + $urandom_range(0, t_step / 2)));
        else
          load_charge(idx, 16'(c_base + idx * c_step + $urandom_range(0, c_step / 2)));
      end else begin
        // out-of-order breakpoints and equal neighbors (zero span)
        idx = $urandom_range(0, 6);
        case ($urandom_range(0, 3))
          0: load_temp(idx, shadow_temp[idx + 1]);
          1: load_charge(idx, shadow_charge[idx + 1]);
          2: load_temp($urandom_range(0, 7), 16'($urandom));
          default: load_charge($urandom_range(0, 7), 16'($urandom));
        endcase
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_word(in_flight);
        words_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (idle_left > 0) begin
          idle_left--;
          s_tvalid <= 1'b0;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].drain_first && pending_readings.size() != 0)) begin
          in_flight = pending_words.pop_front();
          s_tvalid  <= 1'b1;
          s_tdata   <= {2'b00, in_flight.charge, in_flight.temperature,
                        in_flight.load_value, in_flight.col, in_flight.row};
          s_tuser   <= in_flight.kind;
          idle_left = sender_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_readings.size() == 0) begin
          flag($sformatf("result word 0x%08h with no query waiting", m_tdata));
        end else begin
          want = pending_readings.pop_front();
          if (m_tdata[23:0] !== want.resistance)
            flag($sformatf("resistance %0d, predicted %0d", m_tdata[23:0], want.resistance));
          if (m_tdata[25:24] !== want.status)
            flag($sformatf("status %0d, predicted %0d", m_tdata[25:24], want.status));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!steady && $urandom_range(0, 5) == 0) stall_left = pause_len();
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bilinear_table_interpolator_tb failed");
      $finish;
    end
  end

  initial begin
    int unsigned i, j;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // fill every axis and grid entry before any query
    for (i = 0; i < bti_pkg::DEF_TEMP_POINTS; i++) load_temp(i, 16'(20000 + 3000 * i));
    for (i = 0; i < bti_pkg::DEF_CHARGE_POINTS; i++) load_charge(i, 16'(10000 + 6000 * i));
    for (i = 0; i < bti_pkg::DEF_TEMP_POINTS; i++)
      for (j = 0; j < bti_pkg::DEF_CHARGE_POINTS; j++)
        load_grid(i, j, 24'(100000 + i * 20000 + j * 7000 + $urandom_range(0, 999)));

    // extrapolation at the corners, exact breakpoints, top of the search
    query(16'h0000, 16'h0000);
    query(16'hFFFF, 16'hFFFF);
    query(16'h0000, 16'hFFFF);
    query(16'hFFFF, 16'h0000);
    query(shadow_temp[3], shadow_charge[3]);
    query(shadow_temp[3] + 16'd1, shadow_charge[5] - 16'd1);
    query(shadow_temp[7], shadow_charge[0]);
    // saturate high past the top edge
    load_grid(7, 7, bti_pkg::VALUE_MAX);
    load_grid(6, 7, 24'd0);
    query(16'hFFFF, shadow_charge[7]);
    // go negative below the bottom edge
    load_grid(0, 0, 24'd0);
    load_grid(1, 0, bti_pkg::VALUE_MAX);
    query(16'h0000, shadow_charge[0]);
    // exact half rounds up
    query(16'd21500, shadow_charge[0]);
    // zero span on either axis
    load_temp(0, shadow_temp[1]);
    query(16'h0000, 16'd30000);
    load_temp(0, 16'd20000);
    load_charge(7, shadow_charge[6]);
    query(16'd30000, 16'hFFFF);
    load_charge(7, 16'd52000);
    // descending first pair
    load_temp(0, 16'd30000);
    query(16'd10000, 16'd20000);
    load_temp(0, 16'd20000);

    settle();
    set_counts(4'd0, 4'd15);
    run_phase(115);
    settle();
    set_counts(4'd15, 4'd0);
    run_phase(115);
    settle();
    set_counts(4'd2, 4'd2);
    run_phase(115);
    settle();
    set_counts(4'd8, 4'd8);
    steady = 1'b1;
    run_phase(115);
    settle();
    steady = 1'b0;
    set_counts(4'd1, 4'd9);
    run_phase(115);
    settle();
    set_counts(4'd3, 4'd5);
    run_phase(115);
    settle();
    set_counts(4'd7, 4'd2);
    run_phase(115);
    settle();
    set_counts(4'($urandom), 4'($urandom));
    run_phase(115);

    settle();
    if (mismatches == 0) begin
      $display("bilinear_table_interpolator_tb passed");
    end else begin
      $display("bilinear_table_interpolator_tb failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/bti_pkg.sv
hdl/bti_div.sv
hdl/bilinear_table_interpolator.sv
verif/bilinear_table_interpolator_tb.sv
